### hw/rtl/dht_pkg.sv
`timescale 1ns / 1ps

package dht_pkg;

	// default sizes
	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int HANDLE_BITS_DEF = 64;

	// fixed field widths
	localparam int DESC_W = 11;
	localparam int CMD_W  = 2;
	localparam int STAT_W = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_GET    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BADARG  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_MISSING = 2'd2;
	localparam logic [STAT_W-1:0] STAT_FULL    = 2'd3;

	// controller states
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clr_step;
		logic load_in;
		logic exec;
		logic load_out;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
	} dp_stat_t;

endpackage

### hw/rtl/dht_ctrl.sv
`timescale 1ns / 1ps

module dht_ctrl
	import dht_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	output dp_cmd_t  cmd_o,
	input  dp_stat_t stat_i
);

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd_o     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd_o.clr_step = 1'b1;
				if (stat_i.clr_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd_o.load_in = 1'b1;
					state_nxt     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd_o.exec = 1'b1;
				state_nxt  = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd_o.load_out = 1'b1;
					state_nxt      = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
	end

	// output word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_o.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

### hw/rtl/dht_dp.sv
`timescale 1ns / 1ps

module dht_dp
	import dht_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dp_cmd_t                  cmd_i,
	output dp_stat_t                 stat_o,
	input  logic [CMD_W-1:0]         cmd,
	input  logic signed [DESC_W-1:0] descriptor,
	input  logic [HANDLE_BITS-1:0]   handle,
	output logic [HANDLE_BITS-1:0]   handle_out,
	output logic signed [DESC_W-1:0] descriptor_out,
	output logic [STAT_W-1:0]        status
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(TABLE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(TABLE_DEPTH);
	localparam logic [31:0]      DEPTH_32  = 32'(TABLE_DEPTH);

	// storage
	logic [HANDLE_BITS-1:0] handle_mem [TABLE_DEPTH];
	logic                   valid_mem  [TABLE_DEPTH];
	logic [IDX_W-1:0]       fq_mem     [TABLE_DEPTH];

	// free list pointers and counters
	logic [IDX_W-1:0] free_head_q;
	logic [IDX_W-1:0] free_tail_q;
	logic [CNT_W-1:0] free_cnt_q;
	logic [CNT_W-1:0] fresh_q;
	logic [IDX_W-1:0] clr_cnt_q;

	// captured word and read data
	logic [CMD_W-1:0]       cmd_q;
	logic [DESC_W-1:0]      desc_q;
	logic [HANDLE_BITS-1:0] hnd_q;
	logic [IDX_W-1:0]       desc_idx_q;
	logic [HANDLE_BITS-1:0] hnd_rd_q;
	logic                   vld_rd_q;
	logic [IDX_W-1:0]       fq_rd_q;

	// result and output registers
	logic [HANDLE_BITS-1:0] res_hnd_q;
	logic [DESC_W-1:0]      res_desc_q;
	logic [STAT_W-1:0]      res_stat_q;
	logic [HANDLE_BITS-1:0] out_hnd_q;
	logic [DESC_W-1:0]      out_desc_q;
	logic [STAT_W-1:0]      out_stat_q;

	// combinational
	logic [31:0]            desc_ext;
	logic [IDX_W-1:0]       rd_idx;
	logic [31:0]            desc_ext_q;
	logic                   desc_neg;
	logic                   desc_found;
	logic [IDX_W-1:0]       alloc_idx;
	logic [31:0]            alloc_ext;
	logic                   do_pop;
	logic                   do_fresh;
	logic                   do_add;
	logic                   do_remove;
	logic                   do_push;
	logic [HANDLE_BITS-1:0] r_hnd;
	logic [DESC_W-1:0]      r_desc;
	logic [STAT_W-1:0]      r_stat;
	logic                   vm_we;
	logic [IDX_W-1:0]       vm_addr;
	logic                   vm_data;

	// read address from the incoming descriptor
	assign desc_ext = {{(32 - DESC_W){1'b0}}, descriptor};
	assign rd_idx   = desc_ext[IDX_W-1:0];

	// capture the word and read the stores
	always_ff @(posedge clk) begin
		if (cmd_i.load_in) begin
			cmd_q      <= cmd;
			desc_q     <= descriptor;
			hnd_q      <= handle;
			desc_idx_q <= rd_idx;
			hnd_rd_q   <= handle_mem[rd_idx];
			vld_rd_q   <= valid_mem[rd_idx];
			fq_rd_q    <= fq_mem[free_head_q];
		end
	end

	// descriptor check
	assign desc_ext_q = {{(32 - DESC_W){1'b0}}, desc_q};
	assign desc_neg   = desc_q[DESC_W-1];
	assign desc_found = !desc_neg && (desc_ext_q < DEPTH_32) && vld_rd_q;

	// command decode and result
	always_comb begin
		r_hnd     = '1;
		r_desc    = '1;
		r_stat    = STAT_BADARG;
		alloc_idx = fq_rd_q;
		do_pop    = 1'b0;
		do_fresh  = 1'b0;
		do_remove = 1'b0;
		case (cmd_q)
			CMD_GET: begin
				if (desc_neg) begin
					r_stat = STAT_BADARG;
				end else if (desc_found) begin
					r_stat = STAT_OK;
					r_hnd  = hnd_rd_q;
				end else begin
					r_stat = STAT_MISSING;
				end
			end
			CMD_ADD: begin
				if (hnd_q == '1) begin
					r_stat = STAT_BADARG;
				end else if (free_cnt_q != '0) begin
					r_stat = STAT_OK;
					do_pop = 1'b1;
				end else if (fresh_q < CNT_DEPTH) begin
					r_stat    = STAT_OK;
					do_fresh  = 1'b1;
					alloc_idx = fresh_q[IDX_W-1:0];
				end else begin
					r_stat = STAT_FULL;
				end
			end
			CMD_REMOVE: begin
				if (desc_neg) begin
					r_stat = STAT_BADARG;
				end else if (desc_found) begin
					r_stat    = STAT_OK;
					do_remove = 1'b1;
				end else begin
					r_stat = STAT_MISSING;
				end
			end
			default: begin
				r_stat = STAT_BADARG;
			end
		endcase
		do_add    = do_pop || do_fresh;
		alloc_ext = 32'(alloc_idx);
		if (do_add) begin
			r_desc = alloc_ext[DESC_W-1:0];
		end
	end

	assign do_push = do_remove && (free_cnt_q < CNT_DEPTH);

	// valid store port: clearing pass or item update
	always_comb begin
		vm_we   = 1'b0;
		vm_addr = desc_idx_q;
		vm_data = 1'b0;
		if (cmd_i.clr_step) begin
			vm_we   = 1'b1;
			vm_addr = clr_cnt_q;
		end else if (cmd_i.exec && do_add) begin
			vm_we   = 1'b1;
			vm_addr = alloc_idx;
			vm_data = 1'b1;
		end else if (cmd_i.exec && do_remove) begin
			vm_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (vm_we) begin
			valid_mem[vm_addr] <= vm_data;
		end
	end

	// handle store write
	always_ff @(posedge clk) begin
		if (cmd_i.exec && do_add) begin
			handle_mem[alloc_idx] <= hnd_q;
		end
	end

	// free list write
	always_ff @(posedge clk) begin
		if (cmd_i.exec && do_push) begin
			fq_mem[free_tail_q] <= desc_idx_q;
		end
	end

	// pointers, counters and clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			free_tail_q <= '0;
			free_cnt_q  <= '0;
			fresh_q     <= '0;
			clr_cnt_q   <= '0;
		end else begin
			if (cmd_i.clr_step) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cmd_i.exec) begin
				if (do_pop) begin
					free_head_q <= (free_head_q == IDX_LAST) ? '0 : free_head_q + 1'b1;
					free_cnt_q  <= free_cnt_q - 1'b1;
				end
				if (do_fresh) begin
					fresh_q <= fresh_q + 1'b1;
				end
				if (do_push) begin
					free_tail_q <= (free_tail_q == IDX_LAST) ? '0 : free_tail_q + 1'b1;
					free_cnt_q  <= free_cnt_q + 1'b1;
				end
			end
		end
	end

	assign stat_o.clr_last = (clr_cnt_q == IDX_LAST);

	// result hold
	always_ff @(posedge clk) begin
		if (cmd_i.exec) begin
			res_hnd_q  <= r_hnd;
			res_desc_q <= r_desc;
			res_stat_q <= r_stat;
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (cmd_i.load_out) begin
			out_hnd_q  <= res_hnd_q;
			out_desc_q <= res_desc_q;
			out_stat_q <= res_stat_q;
		end
	end

	assign handle_out     = out_hnd_q;
	assign descriptor_out = out_desc_q;
	assign status         = out_stat_q;

endmodule

### hw/rtl/descriptor_handle_table_top.sv
`timescale 1ns / 1ps

// channel  | handshake            | word
// ---------+----------------------+----------------------------------------
// input    | in_valid / in_stall  | cmd, descriptor, handle
// output   | out_valid / out_stall| handle_out, descriptor_out, status
//
// Each word has three steps: capture with the table reads, execute with
// the table writes, then handoff to the output register.
// After reset a clearing pass sweeps the valid store, in_stall held high.
// A new word is taken while the previous result waits in the output
// register; the handoff step holds while out_stall keeps that register full.

module descriptor_handle_table_top
	import dht_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [CMD_W-1:0]         cmd,
	input  logic signed [DESC_W-1:0] descriptor,
	input  logic [HANDLE_BITS-1:0]   handle,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [HANDLE_BITS-1:0]   handle_out,
	output logic signed [DESC_W-1:0] descriptor_out,
	output logic [STAT_W-1:0]        status
);

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	// sequencer
	dht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd_o     (dp_cmd),
		.stat_i    (dp_stat)
	);

	// tables, free list and result registers
	dht_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.HANDLE_BITS (HANDLE_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_i          (dp_cmd),
		.stat_o         (dp_stat),
		.cmd            (cmd),
		.descriptor     (descriptor),
		.handle         (handle),
		.handle_out     (handle_out),
		.descriptor_out (descriptor_out),
		.status         (status)
	);

endmodule
